>>> hw/rtl/iopb_pkg.sv
// Shared types and constants for the I/O port permission bitmap.
// Holds the command word passed from the front end to the back end.
// No dependencies.
`default_nettype none

package iopb_pkg;

  localparam int BITMAP_BYTES_DEF = 8192;
  localparam int PORT_W = 16;
  localparam int WORD_IDX_W = 11;
  localparam int BIT_IDX_W = 5;
  localparam int DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ACTION_GRANT = 2'd0;
  localparam logic [1:0] ACTION_REVOKE = 2'd1;
  localparam logic [1:0] ACTION_CHECK = 2'd2;

  typedef enum logic [1:0] {
    OP_GRANT,
    OP_REVOKE,
    OP_CHECK,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t op;
    logic empty;
    logic [WORD_IDX_W-1:0] word_first;
    logic [WORD_IDX_W-1:0] word_last;
    logic [BIT_IDX_W-1:0] lo;
    logic [BIT_IDX_W-1:0] hi;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic init;
  } back_status_t;

  typedef enum logic [1:0] {
    B_INIT,
    B_IDLE,
    B_SWEEP,
    B_CHECK
  } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/iopb_front.sv
// Front end: takes one word, classifies it and clips its range to the bitmap.
// Depends on iopb_pkg; feeds iopb_queue.
`default_nettype none

module iopb_front #(
  parameter int BITMAP_BYTES = iopb_pkg::BITMAP_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [1:0]                 action,
  input  wire logic [iopb_pkg::PORT_W-1:0] port_first,
  input  wire logic [iopb_pkg::PORT_W-1:0] port_last,
  input  wire iopb_pkg::q_status_t        q_stat,
  output      logic                       ready,
  output      logic                       push,
  output      iopb_pkg::cmd_t             push_cmd
);
  import iopb_pkg::*;

  localparam logic [PORT_W:0] PORTS_X = (PORT_W+1)'(BITMAP_BYTES * 8);
  localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(BITMAP_BYTES * 8 - 1);

  logic held;
  cmd_t cmd;
  cmd_t cmd_next;
  logic in_cov;
  logic [PORT_W-1:0] last_clip;

  always_comb begin
    in_cov = {1'b0, port_first} < PORTS_X;
    last_clip = ({1'b0, port_last} >= PORTS_X) ? PORT_MAX : port_last;
    cmd_next = '0;
    cmd_next.empty = !in_cov;
    cmd_next.word_first = port_first[PORT_W-1:BIT_IDX_W];
    cmd_next.word_last = last_clip[PORT_W-1:BIT_IDX_W];
    cmd_next.lo = port_first[BIT_IDX_W-1:0];
    cmd_next.hi = last_clip[BIT_IDX_W-1:0];
    case (action)
      ACTION_GRANT, ACTION_REVOKE: begin
        cmd_next.op = (action == ACTION_GRANT) ? OP_GRANT : OP_REVOKE;
        if (port_first > port_last) begin
          cmd_next.op = OP_REJECT;
        end
      end
      ACTION_CHECK: begin
        cmd_next.op = OP_CHECK;
      end
      default: begin
        cmd_next.op = OP_REJECT;
      end
    endcase
  end

  assign push = held && !q_stat.full;
  assign ready = !held || !q_stat.full;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/iopb_queue.sv
// Short command queue between the front end and the back end.
// Depends on iopb_pkg.
`default_nettype none

module iopb_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire iopb_pkg::cmd_t     push_cmd,
  input  wire logic               pop,
  output      iopb_pkg::cmd_t     head,
  output      iopb_pkg::q_status_t q_stat
);
  import iopb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  cmd_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head = slots[rd_ptr];
  assign q_stat.full = (count == FULL_COUNT);
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/iopb_back.sv
// Back end: owns the bitmap memory and the present flag, sweeps ranges one
// word per cycle, reads single words for checks and drives the result.
// Depends on iopb_pkg; fed by iopb_queue.
`default_nettype none

module iopb_back #(
  parameter int BITMAP_BYTES = iopb_pkg::BITMAP_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire iopb_pkg::q_status_t q_stat,
  input  wire iopb_pkg::cmd_t      head,
  output      logic                pop,
  output      iopb_pkg::back_status_t b_stat,
  output      logic                done,
  output      logic                status,
  output      logic                allowed
);
  import iopb_pkg::*;

  localparam int WORDS = (BITMAP_BYTES * 8 + DATA_W - 1) / DATA_W;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rd_data;

  back_state_t state, state_next;
  cmd_t cmd, cmd_next;
  logic [AW-1:0] cur, cur_next;
  logic present, present_next;
  logic done_next, status_next, allowed_next;

  logic wr_en;
  logic wr_bit;
  logic [AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_mask;
  logic [BIT_IDX_W-1:0] lo_eff, hi_eff;
  logic [DATA_W-1:0] ones;

  assign b_stat.init = (state == B_INIT);

  always_comb begin
    ones = '1;
    lo_eff = (cur == cmd.word_first[AW-1:0]) ? cmd.lo : '0;
    hi_eff = (cur == cmd.word_last[AW-1:0]) ? cmd.hi : '1;
    state_next = state;
    cmd_next = cmd;
    cur_next = cur;
    present_next = present;
    done_next = 1'b0;
    status_next = status;
    allowed_next = allowed;
    pop = 1'b0;
    wr_en = 1'b0;
    wr_bit = 1'b1;
    wr_addr = cur;
    wr_mask = '1;
    case (state)
      B_INIT: begin
        wr_en = 1'b1;
        cur_next = cur + 1'b1;
        if (cur == LAST_WORD) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          cmd_next = head;
          cur_next = head.word_first[AW-1:0];
          status_next = 1'b0;
          allowed_next = 1'b0;
          case (head.op)
            OP_GRANT: begin
              present_next = 1'b1;
              if (head.empty) begin
                done_next = 1'b1;
              end else begin
                state_next = B_SWEEP;
              end
            end
            OP_REVOKE: begin
              if (!present) begin
                status_next = 1'b1;
                done_next = 1'b1;
              end else if (head.empty) begin
                done_next = 1'b1;
              end else begin
                state_next = B_SWEEP;
              end
            end
            OP_CHECK: begin
              if (!present || head.empty) begin
                done_next = 1'b1;
              end else begin
                state_next = B_CHECK;
              end
            end
            default: begin
              status_next = 1'b1;
              done_next = 1'b1;
            end
          endcase
        end
      end
      B_SWEEP: begin
        wr_en = 1'b1;
        wr_bit = (cmd.op == OP_REVOKE);
        wr_mask = (ones << lo_eff) & (ones >> (5'd31 - hi_eff));
        cur_next = cur + 1'b1;
        if (cur == cmd.word_last[AW-1:0]) begin
          done_next = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_CHECK: begin
        allowed_next = !rd_data[cmd.lo];
        done_next = 1'b1;
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_INIT;
      cur <= '0;
      present <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cur <= cur_next;
      present <= present_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    status <= status_next;
    allowed <= allowed_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < DATA_W; i++) begin
        if (wr_mask[i]) begin
          mem[wr_addr][i] <= wr_bit;
        end
      end
    end
    rd_data <= mem[head.word_first[AW-1:0]];
  end

endmodule

`default_nettype wire

>>> hw/rtl/io_port_permission_bitmap_top.sv
// A word passes the front end's register and a queue slot to the back end; done is
// registered as it takes a rejected word or one that needs no bitmap access, after a
// bitmap read for a check, or after the sweep of a grant or revoke, plus any wait behind
// earlier words. Throughput is set by the back end's single memory write port: one
// bitmap word per cycle, so a full-range grant or revoke writes all 2048 words.
// Reset: after rst the memory is set to all ones, one word per cycle over
// BITMAP_BYTES / 4 words, with busy high; results cannot be stalled.
`default_nettype none

module io_port_permission_bitmap_top #(
  parameter int BITMAP_BYTES = iopb_pkg::BITMAP_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] port_first,
  input  wire logic [15:0] port_last,
  output      logic        done,
  output      logic        status,
  output      logic        allowed
);
  import iopb_pkg::*;

  logic front_ready;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;
  q_status_t q_stat;
  back_status_t b_stat;

  assign busy = b_stat.init || !front_ready;

  iopb_front #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(start && !busy),
    .action(action),
    .port_first(port_first),
    .port_last(port_last),
    .q_stat(q_stat),
    .ready(front_ready),
    .push(push),
    .push_cmd(push_cmd)
  );

  iopb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .pop(pop),
    .head(head),
    .q_stat(q_stat)
  );

  iopb_back #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_stat(q_stat),
    .head(head),
    .pop(pop),
    .b_stat(b_stat),
    .done(done),
    .status(status),
    .allowed(allowed)
  );

  a_allowed_only_on_success: assert property (@(posedge clk) disable iff (rst)
    done |-> !(status && allowed))
    else $error("allowed reported on a rejected word");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("not busy while the bitmap is being initialized");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    b_stat.init |-> !done)
    else $error("result produced during initialization");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> bench/io_port_permission_bitmap_top_tb.sv
// Self-checking testbench for io_port_permission_bitmap_top: grant, revoke and check words
// are compared against a word-level predictor of the permission bitmap and its present flag.
// Depends on iopb_pkg and the io_port_permission_bitmap_top RTL.
`default_nettype none

module io_port_permission_bitmap_top_tb;
  import iopb_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 7;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 265;
  localparam int QUIET_TAIL = 40;
  localparam int BITMAP_BYTES = iopb_pkg::BITMAP_BYTES_DEF;
  localparam int unsigned COVERED_PORTS =
    (BITMAP_BYTES * 8 > 65536) ? 65536 : BITMAP_BYTES * 8;
  localparam logic [1:0] ACTION_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0] action;
    logic [15:0] first;
    logic [15:0] last;
    int unsigned idle_before;
    bit drain_first;
  } port_request_t;

  typedef struct {
    logic status;
    logic allowed;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = '0;
  logic [15:0] port_first = '0;
  logic [15:0] port_last = '0;
  logic busy;
  logic done;
  logic status;
  logic allowed;

  logic taken = 1'b0;
  port_request_t request_queue[$];
  verdict_t pending_verdicts[$];
  logic [31:0] deny_words [2048];
  bit bitmap_exists;
  int mismatches = 0;

  port_request_t staged_req;
  bit staged = 1'b0;
  int unsigned gap_left = 0;

  io_port_permission_bitmap_top #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .port_first(port_first),
    .port_last(port_last),
    .done(done),
    .status(status),
    .allowed(allowed)
  );

  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk = ~clk;
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("[%0t] mismatch on %s: got %0b, expected %0b", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void mark_ports(input int unsigned first, input int unsigned last,
                                     input bit deny);
    int unsigned w;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] mask;
    if (first >= COVERED_PORTS) return;
    if (last >= COVERED_PORTS) last = COVERED_PORTS - 1;
    for (w = first >> 5; w <= (last >> 5); w++) begin
      lo = (w == (first >> 5)) ? (first & 31) : 0;
      hi = (w == (last >> 5)) ? (last & 31) : 31;
      mask = (32'hFFFF_FFFF >> (31 - (hi - lo))) << lo;
      if (deny) begin
        deny_words[w] = deny_words[w] | mask;
      end else begin
        deny_words[w] = deny_words[w] & ~mask;
      end
    end
  endfunction

  function automatic verdict_t predict_verdict(input logic [1:0] act, input logic [15:0] pf,
                                               input logic [15:0] pl);
    verdict_t v;
    logic [31:0] w;
    v.status = 1'b0;
    v.allowed = 1'b0;
    case (act)
      ACTION_GRANT: begin
        if (pf > pl) begin
          v.status = 1'b1;
        end else begin
          bitmap_exists = 1'b1;
          mark_ports(pf, pl, 1'b0);
        end
      end
      ACTION_REVOKE: begin
        if (pf > pl || !bitmap_exists) begin
          v.status = 1'b1;
        end else begin
          mark_ports(pf, pl, 1'b1);
        end
      end
      ACTION_CHECK: begin
        if (bitmap_exists && pf < COVERED_PORTS) begin
          w = deny_words[pf[15:5]];
          v.allowed = ~w[pf[4:0]];
        end
      end
      default: begin
        v.status = 1'b1;
      end
    endcase
    return v;
  endfunction

  task automatic queue_request(input logic [1:0] act, input int unsigned first,
                               input int unsigned last, input int unsigned idle,
                               input bit drain);
    port_request_t r;
    r.action = act;
    r.first = 16'(first);
    r.last = 16'(last);
    r.idle_before = idle;
    r.drain_first = drain;
    request_queue.push_back(r);
  endtask

  // A word is taken at a rising edge where start is high and busy is low.
  always @(posedge clk) begin
    verdict_t want;
    taken <= !rst && start && !busy;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("done", done, 1'b0);
      end else begin
        want = pending_verdicts.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (allowed !== want.allowed) report_mismatch("allowed", allowed, want.allowed);
      end
    end
    if (!rst && start && !busy) begin
      pending_verdicts.push_back(predict_verdict(action, port_first, port_last));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !taken)) begin
      if (!staged && request_queue.size() != 0) begin
        staged_req = request_queue.pop_front();
        staged = 1'b1;
        gap_left = staged_req.idle_before;
      end
      if (staged && gap_left == 0 &&
          !(staged_req.drain_first && pending_verdicts.size() != 0)) begin
        start <= 1'b1;
        action <= staged_req.action;
        port_first <= staged_req.first;
        port_last <= staged_req.last;
        staged = 1'b0;
      end else begin
        start <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned span_kind;
    int unsigned first;
    int unsigned last;
    int unsigned idle;
    int unsigned hot_port;
    logic [1:0] act;

    for (int i = 0; i < 2048; i++) deny_words[i] = 32'hFFFF_FFFF;
    bitmap_exists = 1'b0;
    hot_port = 100;

    queue_request(ACTION_CHECK, 0, 65535, 0, 1'b0);
    queue_request(ACTION_REVOKE, 0, 10, 0, 1'b0);
    queue_request(ACTION_GRANT, 5, 4, 0, 1'b0);
    queue_request(ACTION_CHECK, 5, 0, 0, 1'b0);
    queue_request(ACTION_UNKNOWN, 65535, 65535, 0, 1'b0);
    queue_request(ACTION_GRANT, 0, 0, 0, 1'b0);
    queue_request(ACTION_CHECK, 0, 65535, 0, 1'b0);
    queue_request(ACTION_CHECK, 1, 0, 0, 1'b0);
    queue_request(ACTION_GRANT, 65535, 65535, 0, 1'b0);
    queue_request(ACTION_CHECK, 65535, 12345, 0, 1'b0);
    queue_request(ACTION_GRANT, 100, 200, 0, 1'b0);
    queue_request(ACTION_CHECK, 100, 0, 0, 1'b0);
    queue_request(ACTION_CHECK, 200, 0, 0, 1'b0);
    queue_request(ACTION_CHECK, 99, 0, 0, 1'b0);
    queue_request(ACTION_CHECK, 201, 0, 0, 1'b0);
    queue_request(ACTION_REVOKE, 150, 150, 0, 1'b1);
    queue_request(ACTION_CHECK, 150, 0, 0, 1'b0);
    queue_request(ACTION_CHECK, 151, 0, 0, 1'b0);
    queue_request(ACTION_REVOKE, 300, 299, 0, 1'b0);
    queue_request(ACTION_GRANT, 65535, 0, 0, 1'b0);
    queue_request(ACTION_GRANT, 31, 32, 0, 1'b0);
    queue_request(ACTION_CHECK, 32, 0, 0, 1'b0);
    queue_request(ACTION_GRANT, 0, 65535, 0, 1'b0);
    queue_request(ACTION_CHECK, 12345, 0, 0, 1'b0);
    queue_request(ACTION_REVOKE, 0, 65535, 0, 1'b0);
    queue_request(ACTION_CHECK, 12345, 65535, 0, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      span_kind = $urandom_range(0, 99);
      first = $urandom_range(0, 65535);
      last = first + $urandom_range(0, 100);
      if (span_kind >= 70 && span_kind < 80) begin
        first = first & 32'hFFE0;
        last = first + 32 * $urandom_range(1, 4) - 1;
      end else if (span_kind >= 80 && span_kind < 90) begin
        last = $urandom_range(0, 65534);
        first = last + 1 + $urandom_range(0, 300);
        if (first > 65535) first = 65535;
      end else if (span_kind >= 90 && span_kind < 97) begin
        last = first + $urandom_range(101, 4000);
      end else if (span_kind >= 97) begin
        first = $urandom_range(0, 3);
        last = $urandom_range(65532, 65535);
      end
      if (last > 65535) last = 65535;

      if (pick < 30) begin
        act = ACTION_GRANT;
      end else if (pick < 60) begin
        act = ACTION_REVOKE;
      end else if (pick < 95) begin
        act = ACTION_CHECK;
      end else begin
        act = ACTION_UNKNOWN;
      end

      if (act == ACTION_CHECK) begin
        if ($urandom_range(0, 1) == 1) begin
          first = hot_port + $urandom_range(0, 40);
          if (first > 65535) first = 65535;
        end
        last = $urandom_range(0, 65535);
      end else if (first <= last) begin
        hot_port = first;
      end

      idle = 0;
      if (n < RANDOM_ITEMS - QUIET_TAIL && (n / 30) % 3 != 2 && $urandom_range(0, 2) == 0) begin
        idle = $urandom_range(1, 15);
      end
      queue_request(act, first, last, idle, n == 120 || n == 200);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || staged || start || pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
